@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, gated off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/pdr_pkg.sv @@
// Shared constants, types and arithmetic helpers of the pot dimmer.
package pdr_pkg;

  localparam int NUM_SAMPLES   = 8;
  localparam int SAMPLE_FIELDS = 8;
  localparam int SAMPLE_W      = 12;
  localparam int SAMPLE_CNT    = (NUM_SAMPLES < 1) ? 1 :
                                 ((NUM_SAMPLES > SAMPLE_FIELDS) ? SAMPLE_FIELDS : NUM_SAMPLES);
  localparam int NUM_LANES     = (SAMPLE_CNT + 1) / 2;
  localparam int LSUM_W        = SAMPLE_W + 1;
  localparam int SUM_W         = SAMPLE_W + $clog2(SAMPLE_CNT);
  localparam int AVG_K         = SUM_W + 3;
  localparam int RECIP_W       = AVG_K + 1;
  localparam int AVG_RECIP     = (2 ** AVG_K + SAMPLE_CNT - 1) / SAMPLE_CNT;

  localparam int PCT_W    = 7;
  localparam int DUTY_W   = 8;
  localparam int RP_W     = 8;
  localparam int SMOOTH_W = 20;
  localparam int THR_W    = 7;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam int IN_DATA_W  = RP_W + SAMPLE_FIELDS * SAMPLE_W;  // 104
  localparam int OUT_DATA_W = 24;

  // x/10 = (x * DIV10_M) >> 27, exact for x below 2^24
  localparam logic [26:0] DIV10_M = 27'd13421773;
  // y/100 = (y * DUTY_M) >> 21, exact for y up to 25500
  localparam logic [14:0] DUTY_M  = 15'd20972;

  typedef enum logic [0:0] {
    REG_CHANGE = 1'b0,
    REG_CANCEL = 1'b1
  } cfg_reg_t;

  typedef logic [LSUM_W-1:0] lsum_t;

  typedef struct packed {
    logic            action;
    logic [RP_W-1:0] remote_percent;
  } meta_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic             applied;
    logic             ovr;
  } res_t;

  function automatic logic [SMOOTH_W-1:0] div10(input logic [23:0] x);
    logic [50:0] p;
    p = 51'(x) * 51'(DIV10_M);
    return p[46:27];
  endfunction

  // raw*100/4095 via the divide-by-(2^n - 1) identity
  function automatic logic [PCT_W-1:0] pct_of(input logic [SAMPLE_W-1:0] raw);
    logic [19:0] x;
    logic [19:0] q;
    x = (20'(raw) << 6) + (20'(raw) << 5) + (20'(raw) << 2);
    q = x + (x >> 12) + 20'd1;
    return q[18:12];
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
    logic [14:0] m;
    logic [29:0] p;
    m = (15'(pct) << 8) - 15'(pct);
    p = 30'(m) * 30'(DUTY_M);
    return p[28:21];
  endfunction

  function automatic logic [PCT_W-1:0] abs_diff(input logic [PCT_W-1:0] a,
                                                input logic [PCT_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ sv/pdr_lane.sv @@
// One summing lane: adds a pair of potentiometer readings and registers the sum.
module pdr_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          use_hi,
  input  logic [pdr_pkg::SAMPLE_W-1:0]  s_lo,
  input  logic [pdr_pkg::SAMPLE_W-1:0]  s_hi,
  output pdr_pkg::lsum_t                sum_r
);

  pdr_pkg::lsum_t sum_nxt;

  // drop the upper reading when it lies beyond the sample count
  assign sum_nxt = pdr_pkg::LSUM_W'(s_lo) +
                   (use_hi ? pdr_pkg::LSUM_W'(s_hi) : '0);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

@@ sv/pdr_merge.sv @@
// Merge stage: totals the lane sums and divides by the sample count.
module pdr_merge (
  input  logic                                                    clk,
  input  logic                                                    en,
  input  logic [pdr_pkg::NUM_LANES-1:0][pdr_pkg::LSUM_W-1:0]      lane_sum,
  input  pdr_pkg::meta_t                                          meta_in,
  output logic [pdr_pkg::SAMPLE_W-1:0]                            avg_r,
  output pdr_pkg::meta_t                                          meta_r
);

  localparam int PROD_W = pdr_pkg::SUM_W + pdr_pkg::RECIP_W;

  logic [pdr_pkg::SUM_W-1:0]    total;
  logic [PROD_W-1:0]            prod;
  logic [pdr_pkg::SAMPLE_W-1:0] avg_nxt;

  always_comb begin
    total = '0;
    for (int i = 0; i < pdr_pkg::NUM_LANES; i++) begin
      total = total + pdr_pkg::SUM_W'(lane_sum[i]);
    end
    prod    = PROD_W'(total) * PROD_W'(pdr_pkg::AVG_RECIP);
    avg_nxt = prod[pdr_pkg::AVG_K +: pdr_pkg::SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      avg_r  <= avg_nxt;
      meta_r <= meta_in;
    end
  end

endmodule

@@ sv/pdr_ctrl.sv @@
// Control stage: smoother, percent mapping, override and apply decisions.
module pdr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  pdr_pkg::meta_t                 meta,
  input  logic [pdr_pkg::SAMPLE_W-1:0]   avg,
  input  logic [pdr_pkg::THR_W-1:0]      chg_thr,
  input  logic [pdr_pkg::THR_W-1:0]      cnl_thr,
  output pdr_pkg::res_t                  res_r
);

  logic [pdr_pkg::SMOOTH_W-1:0] smooth_r, smooth_nxt;
  logic                         sval_r, sval_nxt;
  logic                         ovr_r, ovr_nxt;
  logic [pdr_pkg::PCT_W-1:0]    base_r, base_nxt;
  logic [pdr_pkg::PCT_W-1:0]    apct_r, apct_nxt;
  pdr_pkg::res_t                res_nxt;

  logic [pdr_pkg::SMOOTH_W-1:0] avg_q;
  logic [23:0]                  mix;
  logic [pdr_pkg::SMOOTH_W-1:0] smooth_calc;
  logic [pdr_pkg::PCT_W-1:0]    phys;
  logic [pdr_pkg::PCT_W-1:0]    rpct;
  logic                         cancel;
  logic                         do_apply;

  always_comb begin
    avg_q       = {avg, 8'd0};
    mix         = (24'(smooth_r) << 3) + 24'(smooth_r) + 24'(avg_q);
    smooth_calc = sval_r ? pdr_pkg::div10(mix) : avg_q;
    phys        = pdr_pkg::pct_of(smooth_calc[pdr_pkg::SMOOTH_W-1:8]);
    rpct        = (meta.remote_percent > 8'(pdr_pkg::PCT_MAX)) ? pdr_pkg::PCT_MAX
                                                               : meta.remote_percent[6:0];
    cancel      = ovr_r && (pdr_pkg::abs_diff(phys, base_r) >= cnl_thr);
    do_apply    = (!ovr_r || cancel) && (pdr_pkg::abs_diff(phys, apct_r) >= chg_thr);

    smooth_nxt = smooth_r;
    sval_nxt   = sval_r;
    ovr_nxt    = ovr_r;
    base_nxt   = base_r;
    apct_nxt   = apct_r;
    res_nxt    = res_r;

    if (load) begin
      if (meta.action) begin
        // remote request: baseline from the smoother, or the raw average if empty
        apct_nxt = rpct;
        ovr_nxt  = 1'b1;
        base_nxt = sval_r ? pdr_pkg::pct_of(smooth_r[pdr_pkg::SMOOTH_W-1:8])
                          : pdr_pkg::pct_of(avg);
      end else begin
        smooth_nxt = smooth_calc;
        sval_nxt   = 1'b1;
        if (cancel) begin
          ovr_nxt = 1'b0;
        end
        if (do_apply) begin
          apct_nxt = phys;
        end
      end
      res_nxt.pct     = apct_nxt;
      res_nxt.applied = meta.action || do_apply;
      res_nxt.ovr     = ovr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= '0;
      sval_r   <= 1'b0;
      ovr_r    <= 1'b0;
      base_r   <= '0;
      apct_r   <= '0;
    end else begin
      smooth_r <= smooth_nxt;
      sval_r   <= sval_nxt;
      ovr_r    <= ovr_nxt;
      base_r   <= base_nxt;
      apct_r   <= apct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

@@ sv/pot_dimmer_with_remote_override_core.sv @@
// Top level of the pot dimmer with remote override.
//
//   channel   ports                         direction   contents
//   in        in_tvalid/tready/tdata/tuser  slave       eight readings, remote percent
//   out       out_tvalid/tready/tdata       master      brightness and status
//   cfg       cfg_we/addr/wdata             write only  change / cancel thresholds
//
// Four register stages: lanes, merge, control, output; a request passes through
// them in that order before it appears on out_tvalid.
// One request per cycle while out_tready allows; the smoother, override and
// applied level sit in single registers of the control stage that feed back on load.
// Synchronous reset clears all valids and the control state, and loads the
// thresholds with 1 (change) and 8 (cancel).
// An output stall reaches in_tready in the same cycle through the stage enables
// once every stage holds a request; empty stages keep accepting.
module pot_dimmer_with_remote_override_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // remote_percent[7:0], sample_0[19:8] ... sample_7[103:92]
  input  logic [pdr_pkg::IN_DATA_W-1:0]     in_tdata,
  // action[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // brightness[7:0], level_percent[14:8], led_on[15], applied[16],
  // override_active[17], zero fill[23:18]
  output logic [pdr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_addr,
  input  logic [pdr_pkg::THR_W-1:0]         cfg_wdata
);

  logic [pdr_pkg::THR_W-1:0] chg_thr_r;
  logic [pdr_pkg::THR_W-1:0] cnl_thr_r;

  logic a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic a_en, b_en, c_en, d_en;

  logic [pdr_pkg::SAMPLE_FIELDS-1:0][pdr_pkg::SAMPLE_W-1:0] smp;
  logic [pdr_pkg::NUM_LANES-1:0][pdr_pkg::LSUM_W-1:0]       lane_sum;
  pdr_pkg::meta_t                a_meta_r;
  pdr_pkg::meta_t                in_meta;
  pdr_pkg::meta_t                b_meta;
  logic [pdr_pkg::SAMPLE_W-1:0]  b_avg;
  pdr_pkg::res_t                 c_res;

  logic [pdr_pkg::DUTY_W-1:0]    bright_r;
  logic [pdr_pkg::PCT_W-1:0]     level_r;
  logic                          led_r;
  logic                          applied_r;
  logic                          ovr_r;
  logic [pdr_pkg::DUTY_W-1:0]    duty;

  // stage enables: a stage advances when empty or when its successor advances
  assign d_en      = !out_valid_r || out_tready;
  assign c_en      = !c_valid_r || d_en;
  assign b_en      = !b_valid_r || c_en;
  assign a_en      = !a_valid_r || b_en;
  assign in_tready = a_en;

  assign smp                    = in_tdata[pdr_pkg::IN_DATA_W-1:pdr_pkg::RP_W];
  assign in_meta.action         = in_tuser;
  assign in_meta.remote_percent = in_tdata[pdr_pkg::RP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_thr_r <= 7'd1;
      cnl_thr_r <= 7'd8;
    end else if (cfg_we) begin
      case (cfg_addr)
        pdr_pkg::REG_CHANGE: chg_thr_r <= cfg_wdata;
        pdr_pkg::REG_CANCEL: cnl_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_en) a_valid_r   <= in_tvalid;
      if (b_en) b_valid_r   <= a_valid_r;
      if (c_en) c_valid_r   <= b_valid_r;
      if (d_en) out_valid_r <= c_valid_r;
    end
  end

  for (genvar g = 0; g < pdr_pkg::NUM_LANES; g++) begin : g_lane
    pdr_lane u_lane (
      .clk    (clk),
      .en     (a_en),
      .use_hi (1'((2 * g + 1) < pdr_pkg::SAMPLE_CNT)),
      .s_lo   (smp[2 * g]),
      .s_hi   (smp[2 * g + 1]),
      .sum_r  (lane_sum[g])
    );
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_meta_r <= in_meta;
    end
  end

  pdr_merge u_merge (
    .clk      (clk),
    .en       (b_en),
    .lane_sum (lane_sum),
    .meta_in  (a_meta_r),
    .avg_r    (b_avg),
    .meta_r   (b_meta)
  );

  pdr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (c_en && b_valid_r),
    .meta    (b_meta),
    .avg     (b_avg),
    .chg_thr (chg_thr_r),
    .cnl_thr (cnl_thr_r),
    .res_r   (c_res)
  );

  assign duty = pdr_pkg::duty_of(c_res.pct);

  always_ff @(posedge clk) begin
    if (d_en) begin
      bright_r  <= duty;
      level_r   <= c_res.pct;
      led_r     <= (duty != '0);
      applied_r <= c_res.applied;
      ovr_r     <= c_res.ovr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, ovr_r, applied_r, led_r, level_r, bright_r};

endmodule

@@ sv/pdr_chk.sv @@
// Port checker of the pot dimmer, bound to the top level.
`include "assert_macros.svh"

module pdr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pdr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // hold a stalled result
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // lamp flag follows the duty value
  `ASSERT_IMP(a_led_duty, clk, rst_n, out_tvalid, out_tdata[15] == (out_tdata[7:0] != 8'd0))
  // applied level never leaves the percent range
  `ASSERT_IMP(a_pct_range, clk, rst_n, out_tvalid, out_tdata[14:8] <= pdr_pkg::PCT_MAX)
  // full level means full duty
  `ASSERT_IMP(a_full_duty, clk, rst_n, out_tvalid && out_tdata[14:8] == pdr_pkg::PCT_MAX, out_tdata[7:0] == 8'd255)

endmodule

bind pot_dimmer_with_remote_override_core pdr_chk u_pdr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
